// File: hw/rtl/tour_turn_angle_move_evaluator_core_defines.svh
// Assertion macros used by the tour evaluator controller.
`ifndef TOUR_TURN_ANGLE_MOVE_EVALUATOR_CORE_DEFINES_SVH
`define TOUR_TURN_ANGLE_MOVE_EVALUATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTAM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ttam_pkg.sv
// Shared types, codes and constants of the tour evaluator.
`timescale 1ns / 1ps
package ttam_pkg;

  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int ENERGY_MAX  = 8388607;
  localparam int DELTA_W     = 19;
  localparam int ENERGY_W    = 23;
  localparam int IDX_W       = 8;
  localparam int CFG_W       = 9;
  localparam int COORD_IN_W  = 16;
  localparam int ANG_W       = 15;
  localparam int ACC_W       = 18;
  localparam int ATAN_W      = 13;
  localparam int MUL_LAST    = 4;
  localparam int DELTA_JOB_LAST = 9;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENERGY = 2'd1;
  localparam logic [1:0] ACT_EVAL   = 2'd2;
  localparam logic [1:0] ACT_APPLY  = 2'd3;

  // Affected cities of a move, by slot.
  localparam logic [2:0] SL_F = 3'd0;
  localparam logic [2:0] SL_P = 3'd1;
  localparam logic [2:0] SL_S = 3'd2;
  localparam logic [2:0] SL_T = 3'd3;
  localparam logic [2:0] SL_Q = 3'd4;

  typedef enum logic [2:0] {RD_CEN, RD_PRV, RD_NXT, RD_FROM, RD_SHF} ttam_rd_src_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_JSEL, S_RDC, S_RDP, S_RDN, S_ANG, S_WAIT, S_POST,
    S_SH0, S_SHC, S_SHK, S_SHR, S_SHW, S_SHL, S_FIN
  } ttam_state_t;

  typedef enum logic [2:0] {
    AP_IDLE, AP_MUL, AP_PREP, AP_ITER, AP_FIN, AP_DONE
  } ttam_aph_t;

  typedef struct packed {
    logic         latch_in;
    logic         setup;
    logic         load_wr;
    logic         rd_en;
    ttam_rd_src_t rd_src;
    logic         cap_c;
    logic         cap_p;
    logic         ang_start;
    logic         ang_acc;
    logic         job_inc;
    logic         energy_commit;
    logic         energy_zero;
    logic         delta_set;
    logic         apply_commit;
    logic         sh_cap;
    logic         sh_wr;
    logic         sh_last;
    logic         out_load;
  } ttam_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_energy;
    logic is_apply;
    logic small_tour;
    logic mv_ok;
    logic mv_delta;
    logic job_skip;
    logic job_last;
    logic ang_done;
    logic sh_done;
  } ttam_sts_t;

  // Rounded arctangent of 2^-i in unsigned Q0.13 radians.
  function automatic logic [ATAN_W-1:0] atan_q13(input logic [4:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:  r = 13'd6434;
      5'd1:  r = 13'd3798;
      5'd2:  r = 13'd2007;
      5'd3:  r = 13'd1019;
      5'd4:  r = 13'd511;
      5'd5:  r = 13'd256;
      5'd6:  r = 13'd128;
      5'd7:  r = 13'd64;
      5'd8:  r = 13'd32;
      5'd9:  r = 13'd16;
      5'd10: r = 13'd8;
      5'd11: r = 13'd4;
      5'd12: r = 13'd2;
      5'd13: r = 13'd1;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/ttam_angle.sv
// Iterative turning-angle unit: edge products, then CORDIC vectoring.
`timescale 1ns / 1ps
module ttam_angle #(
  parameter int COORD_BITS   = 16,
  parameter int CORDIC_STEPS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [COORD_BITS-1:0]        c_x,
  input  logic signed [COORD_BITS-1:0]        c_y,
  input  logic signed [COORD_BITS-1:0]        p_x,
  input  logic signed [COORD_BITS-1:0]        p_y,
  input  logic signed [COORD_BITS-1:0]        n_x,
  input  logic signed [COORD_BITS-1:0]        n_y,
  output logic                                done,
  output logic [ttam_pkg::ANG_W-1:0]          angle
);

  localparam int D  = COORD_BITS + 1;
  localparam int W  = 2 * COORD_BITS + 5;
  localparam int KW = $clog2(CORDIC_STEPS);
  localparam int AC = ttam_pkg::ACC_W;

  ttam_pkg::ttam_aph_t ph_r, ph_nxt;

  logic        [KW-1:0]  k_r;
  logic signed [D-1:0]   ax_r, ay_r, bx_r, by_r;
  logic                  zero_r;
  logic signed [D-1:0]   mul_a, mul_b;
  logic signed [2*D-1:0] prod_c, prod_r;
  logic signed [W-1:0]   dot_r, crs_r, crs_abs, x_r, y_r, xs, ys;
  logic signed [AC-1:0]  acc_r, atan_s;
  logic [ttam_pkg::ANG_W-1:0] ang_r;

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      ttam_pkg::AP_IDLE: if (start) ph_nxt = ttam_pkg::AP_MUL;
      ttam_pkg::AP_MUL:  if (k_r == KW'(ttam_pkg::MUL_LAST)) ph_nxt = ttam_pkg::AP_PREP;
      ttam_pkg::AP_PREP: begin
        if (zero_r || crs_abs == '0) ph_nxt = ttam_pkg::AP_DONE;
        else ph_nxt = ttam_pkg::AP_ITER;
      end
      ttam_pkg::AP_ITER: if (k_r == KW'(CORDIC_STEPS - 1)) ph_nxt = ttam_pkg::AP_FIN;
      ttam_pkg::AP_FIN:  ph_nxt = ttam_pkg::AP_DONE;
      ttam_pkg::AP_DONE: ph_nxt = ttam_pkg::AP_IDLE;
      default:           ph_nxt = ttam_pkg::AP_IDLE;
    endcase
  end

  always_comb begin
    case (k_r)
      KW'(0):  begin mul_a = ax_r; mul_b = bx_r; end
      KW'(1):  begin mul_a = ay_r; mul_b = by_r; end
      KW'(2):  begin mul_a = ax_r; mul_b = by_r; end
      default: begin mul_a = ay_r; mul_b = bx_r; end
    endcase
  end

  assign prod_c  = mul_a * mul_b;
  assign crs_abs = crs_r[W-1] ? -crs_r : crs_r;
  assign xs      = x_r >>> k_r;
  assign ys      = y_r >>> k_r;
  assign atan_s  = signed'(AC'(ttam_pkg::atan_q13(5'(k_r))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= ttam_pkg::AP_IDLE;
      k_r  <= '0;
    end else begin
      ph_r <= ph_nxt;
      if ((ph_r == ttam_pkg::AP_MUL || ph_r == ttam_pkg::AP_ITER) && ph_nxt == ph_r)
        k_r <= k_r + 1'b1;
      else
        k_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      ttam_pkg::AP_IDLE: begin
        if (start) begin
          ax_r   <= D'(p_x) - D'(c_x);
          ay_r   <= D'(p_y) - D'(c_y);
          bx_r   <= D'(n_x) - D'(c_x);
          by_r   <= D'(n_y) - D'(c_y);
          zero_r <= (p_x == c_x && p_y == c_y) || (n_x == c_x && n_y == c_y);
        end
      end
      ttam_pkg::AP_MUL: begin
        prod_r <= prod_c;
        case (k_r)
          KW'(1):  dot_r <= W'(prod_r);
          KW'(2):  dot_r <= dot_r + W'(prod_r);
          KW'(3):  crs_r <= W'(prod_r);
          KW'(4):  crs_r <= crs_r - W'(prod_r);
          default: ;
        endcase
      end
      ttam_pkg::AP_PREP: begin
        if (zero_r) begin
          ang_r <= ttam_pkg::ANG_W'(ttam_pkg::PI_Q13);
        end else if (crs_abs == '0) begin
          ang_r <= (dot_r > 0) ? '0 : ttam_pkg::ANG_W'(ttam_pkg::PI_Q13);
        end else if (dot_r[W-1]) begin
          // Rotate by a quarter turn so that vectoring starts in the right half plane.
          x_r   <= crs_abs;
          y_r   <= -dot_r;
          acc_r <= AC'(ttam_pkg::HALF_PI_Q13);
        end else begin
          x_r   <= dot_r;
          y_r   <= crs_abs;
          acc_r <= '0;
        end
      end
      ttam_pkg::AP_ITER: begin
        if (!y_r[W-1]) begin
          x_r   <= x_r + ys;
          y_r   <= y_r - xs;
          acc_r <= acc_r + atan_s;
        end else begin
          x_r   <= x_r - ys;
          y_r   <= y_r + xs;
          acc_r <= acc_r - atan_s;
        end
      end
      ttam_pkg::AP_FIN: begin
        if (acc_r < 0) ang_r <= '0;
        else if (acc_r > AC'(ttam_pkg::PI_Q13)) ang_r <= ttam_pkg::ANG_W'(ttam_pkg::PI_Q13);
        else ang_r <= ttam_pkg::ANG_W'(acc_r);
      end
      default: ;
    endcase
  end

  assign done  = (ph_r == ttam_pkg::AP_DONE);
  assign angle = ang_r;

endmodule

// File: hw/rtl/ttam_dp.sv
// Datapath: city memory, tour indexing, angle unit, accumulators, result register.
`timescale 1ns / 1ps
module ttam_dp #(
  parameter int MAX_CITIES   = 256,
  parameter int COORD_BITS   = 16,
  parameter int CORDIC_STEPS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ttam_pkg::ttam_cmd_t                    cmd,
  output ttam_pkg::ttam_sts_t                    sts,
  input  logic                                   cfg_we,
  input  logic [ttam_pkg::CFG_W-1:0]             cfg_data,
  input  logic [1:0]                             in_action,
  input  logic [ttam_pkg::IDX_W-1:0]             in_from_index,
  input  logic [ttam_pkg::IDX_W-1:0]             in_to_index,
  input  logic signed [ttam_pkg::COORD_IN_W-1:0] in_coord_x,
  input  logic signed [ttam_pkg::COORD_IN_W-1:0] in_coord_y,
  output logic signed [ttam_pkg::DELTA_W-1:0]    out_energy_delta,
  output logic [ttam_pkg::ENERGY_W-1:0]          out_total_energy
);

  localparam int C  = COORD_BITS;
  localparam int IW = $clog2(MAX_CITIES);
  localparam int NW = $clog2(MAX_CITIES + 1);
  localparam int JW = (IW > 4) ? IW : 4;
  localparam int AW = IW + 17;
  localparam int EW = ttam_pkg::ENERGY_W;
  localparam int SW = ((AW > EW) ? AW : EW) + 2;

  logic [2*C-1:0] mem [MAX_CITIES];
  logic [2*C-1:0] rd_data_r, cc_r, cp_r, fx_r;

  logic [1:0]                   act_r;
  logic [ttam_pkg::IDX_W-1:0]   from_r, to_r;
  logic [C-1:0]                 lx_r, ly_r;
  logic [ttam_pkg::CFG_W-1:0]   cnt_r;
  logic [IW-1:0]                f_r, p_r, s_r, t_r, q_r, sp_r, end_r;
  logic                         up_r, emode_r;
  logic [JW-1:0]                job_r;
  logic signed [AW-1:0]         acc_r;
  logic signed [ttam_pkg::DELTA_W-1:0] delta_r, out_delta_r;
  logic [EW-1:0]                energy_r, out_total_r;

  logic [NW-1:0]  n_c;
  logic [IW-1:0]  nm1, fi, ti, p_c, s_c, cen, oprv, onxt, nprv, nnxt, aprv, anxt;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic [2*C-1:0] wr_data;
  logic           wr_en, use_new, load_ok;
  logic [2:0]     slot;
  logic           ang_done;
  logic [ttam_pkg::ANG_W-1:0] ang;
  logic signed [AW-1:0] ang_ext;
  logic signed [SW-1:0] e_sum;

  function automatic logic [IW-1:0] prv(input logic [IW-1:0] c, input logic [IW-1:0] last);
    return (c == '0) ? last : c - 1'b1;
  endfunction

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] c, input logic [IW-1:0] last);
    return (c == last) ? '0 : c + 1'b1;
  endfunction

  assign n_c  = (32'(cnt_r) > 32'(MAX_CITIES)) ? NW'(MAX_CITIES) : NW'(cnt_r);
  assign nm1  = IW'(n_c - 1'b1);
  assign fi   = IW'(from_r);
  assign ti   = IW'(to_r);
  assign p_c  = prv(fi, nm1);
  assign s_c  = nxt(fi, nm1);
  assign slot = job_r[3:1];
  assign use_new = !emode_r && job_r[0];
  assign load_ok = 32'(from_r) < 32'(MAX_CITIES);

  always_comb begin
    if (emode_r) begin
      cen = IW'(job_r);
    end else begin
      case (slot)
        ttam_pkg::SL_F: cen = f_r;
        ttam_pkg::SL_P: cen = p_r;
        ttam_pkg::SL_S: cen = s_r;
        ttam_pkg::SL_T: cen = t_r;
        default:        cen = q_r;
      endcase
    end
  end

  // Neighbors of a city before and after the move, in positions of the old tour.
  assign oprv = prv(cen, nm1);
  assign onxt = nxt(cen, nm1);
  assign nprv = (cen == s_r) ? p_r : (cen == t_r) ? f_r : (cen == f_r) ? q_r : oprv;
  assign nnxt = (cen == p_r) ? s_r : (cen == q_r) ? f_r : (cen == f_r) ? t_r : onxt;
  assign aprv = use_new ? nprv : oprv;
  assign anxt = use_new ? nnxt : onxt;

  always_comb begin
    sts            = '0;
    sts.is_load    = (act_r == ttam_pkg::ACT_LOAD);
    sts.is_energy  = (act_r == ttam_pkg::ACT_ENERGY);
    sts.is_apply   = (act_r == ttam_pkg::ACT_APPLY);
    sts.small_tour = (n_c < NW'(2));
    sts.mv_ok      = (n_c >= NW'(4)) && (32'(from_r) < 32'(n_c)) && (32'(to_r) < 32'(n_c));
    sts.mv_delta   = (ti != fi) && (ti != s_c);
    sts.job_skip   = !emode_r && ((slot == ttam_pkg::SL_T && t_r == p_r) ||
                                  (slot == ttam_pkg::SL_Q && q_r == s_r));
    sts.job_last   = emode_r ? (job_r == JW'(n_c - 1'b1))
                             : (job_r == JW'(ttam_pkg::DELTA_JOB_LAST));
    sts.ang_done   = ang_done;
    sts.sh_done    = (sp_r == end_r);
  end

  always_comb begin
    case (cmd.rd_src)
      ttam_pkg::RD_CEN:  rd_addr = cen;
      ttam_pkg::RD_PRV:  rd_addr = aprv;
      ttam_pkg::RD_NXT:  rd_addr = anxt;
      ttam_pkg::RD_FROM: rd_addr = f_r;
      ttam_pkg::RD_SHF:  rd_addr = up_r ? sp_r + 1'b1 : sp_r - 1'b1;
      default:           rd_addr = cen;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sp_r;
    wr_data = rd_data_r;
    if (cmd.load_wr) begin
      wr_en   = load_ok;
      wr_addr = fi;
      wr_data = {lx_r, ly_r};
    end else if (cmd.sh_wr) begin
      wr_en = 1'b1;
    end else if (cmd.sh_last) begin
      wr_en   = 1'b1;
      wr_data = fx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  ttam_angle #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.ang_start),
    .c_x   (signed'(cc_r[2*C-1:C])),
    .c_y   (signed'(cc_r[C-1:0])),
    .p_x   (signed'(cp_r[2*C-1:C])),
    .p_y   (signed'(cp_r[C-1:0])),
    .n_x   (signed'(rd_data_r[2*C-1:C])),
    .n_y   (signed'(rd_data_r[C-1:0])),
    .done  (ang_done),
    .angle (ang)
  );

  assign ang_ext = signed'(AW'(ang));
  assign e_sum   = signed'(SW'(energy_r)) + SW'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      energy_r <= '0;
    end else begin
      if (cfg_we) cnt_r <= cfg_data;
      if (cmd.energy_zero) begin
        energy_r <= '0;
      end else if (cmd.energy_commit) begin
        if (64'(acc_r) > 64'(ttam_pkg::ENERGY_MAX)) energy_r <= EW'(ttam_pkg::ENERGY_MAX);
        else energy_r <= EW'(acc_r);
      end else if (cmd.apply_commit) begin
        if (e_sum < 0) energy_r <= '0;
        else if (e_sum > SW'(ttam_pkg::ENERGY_MAX)) energy_r <= EW'(ttam_pkg::ENERGY_MAX);
        else energy_r <= EW'(e_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r   <= in_action;
      from_r  <= in_from_index;
      to_r    <= in_to_index;
      lx_r    <= C'({16'd0, in_coord_x});
      ly_r    <= C'({16'd0, in_coord_y});
      delta_r <= '0;
    end
    if (cmd.setup) begin
      f_r     <= fi;
      p_r     <= p_c;
      s_r     <= s_c;
      t_r     <= ti;
      q_r     <= prv(ti, nm1);
      sp_r    <= fi;
      up_r    <= (ti > fi);
      end_r   <= (ti > fi) ? ti - 1'b1 : ti;
      emode_r <= (act_r == ttam_pkg::ACT_ENERGY);
      job_r   <= '0;
      acc_r   <= '0;
    end
    if (cmd.job_inc) job_r <= job_r + 1'b1;
    if (cmd.cap_c) cc_r <= rd_data_r;
    if (cmd.cap_p) cp_r <= rd_data_r;
    if (cmd.ang_acc) begin
      if (emode_r) acc_r <= acc_r + AW'(ttam_pkg::PI_Q13) - ang_ext;
      else if (use_new) acc_r <= acc_r - ang_ext;
      else acc_r <= acc_r + ang_ext;
    end
    if (cmd.delta_set) delta_r <= ttam_pkg::DELTA_W'(acc_r);
    if (cmd.sh_cap) fx_r <= rd_data_r;
    if (cmd.sh_wr) sp_r <= up_r ? sp_r + 1'b1 : sp_r - 1'b1;
    if (cmd.out_load) begin
      out_delta_r <= delta_r;
      out_total_r <= energy_r;
    end
  end

  assign out_energy_delta = out_delta_r;
  assign out_total_energy = out_total_r;

endmodule

// File: hw/rtl/ttam_ctrl.sv
// Controller state machine sequencing loads, angle jobs, tour shifts and result beats.
`timescale 1ns / 1ps
`include "tour_turn_angle_move_evaluator_core_defines.svh"
module ttam_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ttam_pkg::ttam_sts_t sts,
  output ttam_pkg::ttam_cmd_t cmd
);

  ttam_pkg::ttam_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt, out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttam_pkg::S_IDLE: if (in_valid) state_nxt = ttam_pkg::S_DEC;
      ttam_pkg::S_DEC: begin
        if (sts.is_load) state_nxt = ttam_pkg::S_FIN;
        else if (sts.is_energy) state_nxt = sts.small_tour ? ttam_pkg::S_FIN : ttam_pkg::S_JSEL;
        else if (!sts.mv_ok) state_nxt = ttam_pkg::S_FIN;
        else if (sts.mv_delta) state_nxt = ttam_pkg::S_JSEL;
        else if (sts.is_apply) state_nxt = ttam_pkg::S_SH0;
        else state_nxt = ttam_pkg::S_FIN;
      end
      ttam_pkg::S_JSEL: begin
        if (!sts.job_skip) state_nxt = ttam_pkg::S_RDC;
        else if (sts.job_last) state_nxt = ttam_pkg::S_POST;
      end
      ttam_pkg::S_RDC: state_nxt = ttam_pkg::S_RDP;
      ttam_pkg::S_RDP: state_nxt = ttam_pkg::S_RDN;
      ttam_pkg::S_RDN: state_nxt = ttam_pkg::S_ANG;
      ttam_pkg::S_ANG: state_nxt = ttam_pkg::S_WAIT;
      ttam_pkg::S_WAIT: begin
        if (sts.ang_done) state_nxt = sts.job_last ? ttam_pkg::S_POST : ttam_pkg::S_JSEL;
      end
      ttam_pkg::S_POST: begin
        if (!sts.is_energy && sts.is_apply) state_nxt = ttam_pkg::S_SH0;
        else state_nxt = ttam_pkg::S_FIN;
      end
      ttam_pkg::S_SH0: state_nxt = ttam_pkg::S_SHC;
      ttam_pkg::S_SHC: state_nxt = ttam_pkg::S_SHK;
      ttam_pkg::S_SHK: state_nxt = sts.sh_done ? ttam_pkg::S_SHL : ttam_pkg::S_SHR;
      ttam_pkg::S_SHR: state_nxt = ttam_pkg::S_SHW;
      ttam_pkg::S_SHW: state_nxt = ttam_pkg::S_SHK;
      ttam_pkg::S_SHL: state_nxt = ttam_pkg::S_FIN;
      ttam_pkg::S_FIN: if (out_free) state_nxt = ttam_pkg::S_IDLE;
      default:         state_nxt = ttam_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ttam_pkg::S_IDLE);
    case (state_r)
      ttam_pkg::S_IDLE: cmd.latch_in = in_valid;
      ttam_pkg::S_DEC: begin
        cmd.setup       = 1'b1;
        cmd.load_wr     = sts.is_load;
        cmd.energy_zero = sts.is_energy && sts.small_tour;
      end
      ttam_pkg::S_JSEL: cmd.job_inc = sts.job_skip && !sts.job_last;
      ttam_pkg::S_RDC: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ttam_pkg::RD_CEN;
      end
      ttam_pkg::S_RDP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ttam_pkg::RD_PRV;
        cmd.cap_c  = 1'b1;
      end
      ttam_pkg::S_RDN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ttam_pkg::RD_NXT;
        cmd.cap_p  = 1'b1;
      end
      ttam_pkg::S_ANG: cmd.ang_start = 1'b1;
      ttam_pkg::S_WAIT: begin
        cmd.ang_acc = sts.ang_done;
        cmd.job_inc = sts.ang_done && !sts.job_last;
      end
      ttam_pkg::S_POST: begin
        cmd.energy_commit = sts.is_energy;
        cmd.delta_set     = !sts.is_energy;
        cmd.apply_commit  = !sts.is_energy && sts.is_apply;
      end
      ttam_pkg::S_SH0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ttam_pkg::RD_FROM;
      end
      ttam_pkg::S_SHC: cmd.sh_cap = 1'b1;
      ttam_pkg::S_SHR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ttam_pkg::RD_SHF;
      end
      ttam_pkg::S_SHW: cmd.sh_wr = 1'b1;
      ttam_pkg::S_SHL: cmd.sh_last = 1'b1;
      ttam_pkg::S_FIN: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttam_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TTAM_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_r == ttam_pkg::S_DEC, "accepted beat did not enter decode")
  `TTAM_ASSERT_SAME(a_result_from_fin, $rose(out_valid_r), $past(state_r == ttam_pkg::S_FIN), "result beat raised outside finish")
  `TTAM_ASSERT_NEXT(a_angle_done_moves, state_r == ttam_pkg::S_WAIT && sts.ang_done, state_r == ttam_pkg::S_JSEL || state_r == ttam_pkg::S_POST, "angle result not consumed")

endmodule

// File: hw/rtl/tour_turn_angle_move_evaluator_core.sv
// Top level of the tour turning-angle energy and move evaluator.
`timescale 1ns / 1ps
// Takes one item at a time and returns one result beat per item. Every turning angle
// takes three reads of the city memory's one read port, four passes through one shared
// multiplier, the CORDIC iterations and the hand-off. An energy recompute takes one
// angle per city of the tour and an evaluate takes up to ten angles. An apply adds a
// tour shift of a check, a read and a write per city moved, plus a fetch and a place
// of the moved city. A new item is accepted while the previous result beat still
// waits on out_stall.
module tour_turn_angle_move_evaluator_core #(
  parameter int MAX_CITIES   = 256,
  parameter int COORD_BITS   = 16,
  parameter int CORDIC_STEPS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ttam_pkg::CFG_W-1:0]             cfg_city_count,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_action,
  input  logic [ttam_pkg::IDX_W-1:0]             in_from_index,
  input  logic [ttam_pkg::IDX_W-1:0]             in_to_index,
  input  logic signed [ttam_pkg::COORD_IN_W-1:0] in_coord_x,
  input  logic signed [ttam_pkg::COORD_IN_W-1:0] in_coord_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ttam_pkg::DELTA_W-1:0]    out_energy_delta,
  output logic [ttam_pkg::ENERGY_W-1:0]          out_total_energy
);

  ttam_pkg::ttam_cmd_t cmd;
  ttam_pkg::ttam_sts_t sts;

  assign cfg_ready = 1'b1;

  ttam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttam_dp #(
    .MAX_CITIES   (MAX_CITIES),
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_city_count),
    .in_action        (in_action),
    .in_from_index    (in_from_index),
    .in_to_index      (in_to_index),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .out_energy_delta (out_energy_delta),
    .out_total_energy (out_total_energy)
  );

endmodule

// File: bench/tb_tour_turn_angle_move_evaluator_core.sv
// Self-checking testbench of the tour turning-angle move evaluator core.
`timescale 1ns / 1ps

module tb_tour_turn_angle_move_evaluator_core;

  localparam int NCITY = 256;
  localparam int STEPS = 14;

  typedef struct {
    logic signed [ttam_pkg::DELTA_W-1:0] delta;
    logic [ttam_pkg::ENERGY_W-1:0]       total;
  } tour_result_t;

  // Tracks the tour and the energy, and holds the results still owed.
  class tour_scoreboard;
    longint cx[NCITY], cy[NCITY], mx[NCITY], my[NCITY];
    longint energy;
    int     count;
    int     errors;
    int     atan_tab[STEPS] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16,
                                8, 4, 2, 1};
    tour_result_t pending[$];

    function longint turn_angle(longint c_x, longint c_y, longint p_x, longint p_y,
                                longint n_x, longint n_y);
      longint ax, ay, bx, by, dot, crs, x, y, t, xs, ys, acc;
      ax = p_x - c_x; ay = p_y - c_y;
      bx = n_x - c_x; by = n_y - c_y;
      acc = 0;
      if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return ttam_pkg::PI_Q13;
      dot = ax * bx + ay * by;
      crs = ax * by - ay * bx;
      if (crs < 0) crs = -crs;
      if (crs == 0) return (dot > 0) ? 0 : ttam_pkg::PI_Q13;
      x = dot;
      y = crs;
      // Rotate an obtuse pair into the right half plane first.
      if (x < 0) begin
        t = x; x = y; y = -t;
        acc = ttam_pkg::HALF_PI_Q13;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; acc = acc + atan_tab[i];
        end else begin
          x = x - ys; y = y + xs; acc = acc - atan_tab[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > ttam_pkg::PI_Q13) acc = ttam_pkg::PI_Q13;
      return acc;
    endfunction

    function longint tour_sum(bit moved, int n);
      longint sum;
      int pv, nx;
      sum = 0;
      if (n < 2) return 0;
      for (int i = 0; i < n; i++) begin
        pv = (i == 0) ? n - 1 : i - 1;
        nx = (i == n - 1) ? 0 : i + 1;
        if (moved)
          sum += ttam_pkg::PI_Q13 - turn_angle(mx[i], my[i], mx[pv], my[pv], mx[nx], my[nx]);
        else
          sum += ttam_pkg::PI_Q13 - turn_angle(cx[i], cy[i], cx[pv], cy[pv], cx[nx], cy[nx]);
      end
      return sum;
    endfunction

    function void build_move(int n, int from, int to);
      int slot, k;
      slot = (to > from) ? to - 1 : to;
      k = 0;
      for (int j = 0; j < n; j++) begin
        if (j != from) begin
          if (k == slot) begin
            mx[k] = cx[from]; my[k] = cy[from]; k++;
          end
          mx[k] = cx[j]; my[k] = cy[j]; k++;
        end
      end
      if (k == slot) begin
        mx[k] = cx[from]; my[k] = cy[from];
      end
    endfunction

    function void note_item(logic [1:0] act, int from, int to,
                            logic signed [15:0] x, logic signed [15:0] y);
      int n, succ;
      longint d, e;
      tour_result_t r;
      n = (count > NCITY) ? NCITY : count;
      d = 0;
      if (act == ttam_pkg::ACT_LOAD) begin
        cx[from] = x; cy[from] = y;
      end else if (act == ttam_pkg::ACT_ENERGY) begin
        e = tour_sum(0, n);
        energy = (e > ttam_pkg::ENERGY_MAX) ? ttam_pkg::ENERGY_MAX : e;
      end else if (n >= 4 && from < n && to < n) begin
        succ = (from == n - 1) ? 0 : from + 1;
        build_move(n, from, to);
        if (to != from && to != succ) d = tour_sum(1, n) - tour_sum(0, n);
        if (act == ttam_pkg::ACT_APPLY) begin
          e = energy + d;
          if (e < 0) e = 0;
          if (e > ttam_pkg::ENERGY_MAX) e = ttam_pkg::ENERGY_MAX;
          energy = e;
          for (int i = 0; i < n; i++) begin
            cx[i] = mx[i]; cy[i] = my[i];
          end
        end
      end
      r.delta = d[ttam_pkg::DELTA_W-1:0];
      r.total = energy[ttam_pkg::ENERGY_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [ttam_pkg::DELTA_W-1:0] d,
                               logic [ttam_pkg::ENERGY_W-1:0] e);
      tour_result_t r;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: delta %0d total %0d", d, e);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (d !== r.delta) begin
        $error("energy_delta: expected %0d, actual %0d", r.delta, d);
        errors++;
      end
      if (e !== r.total) begin
        $error("total_energy: expected %0d, actual %0d", r.total, e);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ttam_pkg::CFG_W-1:0] cfg_city_count = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ttam_pkg::ACT_LOAD;
  logic [ttam_pkg::IDX_W-1:0] in_from_index = '0;
  logic [ttam_pkg::IDX_W-1:0] in_to_index = '0;
  logic signed [ttam_pkg::COORD_IN_W-1:0] in_coord_x = '0;
  logic signed [ttam_pkg::COORD_IN_W-1:0] in_coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ttam_pkg::DELTA_W-1:0] out_energy_delta;
  logic [ttam_pkg::ENERGY_W-1:0] out_total_energy;

  bit quiet = 1'b0;
  tour_scoreboard sb = new();

  tour_turn_angle_move_evaluator_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_city_count(cfg_city_count),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_from_index(in_from_index), .in_to_index(in_to_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_energy_delta(out_energy_delta), .out_total_energy(out_total_energy)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
  end

  // Handshake signals settle well before the falling edge, so a beat seen
  // there is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_energy_delta, out_total_energy);
  end

  task automatic send_item(logic [1:0] act, int from, int to,
                           logic signed [15:0] x, logic signed [15:0] y);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_from_index <= from[ttam_pkg::IDX_W-1:0];
    in_to_index <= to[ttam_pkg::IDX_W-1:0];
    in_coord_x <= x;
    in_coord_y <= y;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    sb.note_item(act, from, to, x, y);
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_city_count(int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_city_count <= value[ttam_pkg::CFG_W-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.count = value;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(6)) - 16'sd3;
      2: begin
        case ($urandom_range(4))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'($urandom_range(65535));
        endcase
      end
      default: return 16'($urandom_range(400)) - 16'sd200;
    endcase
  endfunction

  task automatic run_phase(int value, int items, int mode);
    int ne, r, from, to, k;
    ne = (value > NCITY) ? NCITY : value;
    write_city_count(value);
    for (int i = 0; i < ne; i++) begin
      send_item(ttam_pkg::ACT_LOAD, i, 0, pick_coord(mode), pick_coord(mode));
    end
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      from = (ne > 0 && $urandom_range(9) != 0) ? $urandom_range(ne - 1) : $urandom_range(255);
      if (r < 22) begin
        send_item(ttam_pkg::ACT_LOAD, (from < ne) ? from : $urandom_range(255), 0,
                  pick_coord(mode), pick_coord(mode));
      end else if (r < 32) begin
        send_item(ttam_pkg::ACT_ENERGY, from, $urandom_range(255), pick_coord(0),
                  pick_coord(0));
      end else begin
        k = $urandom_range(5);
        if (ne == 0 || k == 3) to = $urandom_range(255);
        else if (k == 0) to = from;
        else if (k == 1) to = (from + 1) % ne;
        else if (k == 2) to = (from + ne - 1) % ne;
        else to = $urandom_range(ne - 1);
        send_item((r < 66) ? ttam_pkg::ACT_EVAL : ttam_pkg::ACT_APPLY, from, to,
                  pick_coord(0), pick_coord(0));
      end
      // Now and then hold the next beat until every result is back.
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int counts[18];
    counts = '{4, 5, 6, 7, 8, 3, 2, 1, 0, 4, 12, 256, 511, 9, 16, 4, 10, 5};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Square tour, then every kind of move on it.
    write_city_count(4);
    send_item(ttam_pkg::ACT_LOAD, 0, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_LOAD, 1, 0, 16'sd100, 16'sd0);
    send_item(ttam_pkg::ACT_LOAD, 2, 0, 16'sd100, 16'sd100);
    send_item(ttam_pkg::ACT_LOAD, 3, 0, 16'sd0, 16'sd100);
    send_item(ttam_pkg::ACT_ENERGY, 0, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_EVAL, 0, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_EVAL, 0, 1, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_EVAL, 0, 3, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_EVAL, 1, 3, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_APPLY, 0, 2, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_APPLY, 3, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_EVAL, 4, 255, 16'sd0, 16'sd0);
    // A city on top of its neighbor, then a straight line.
    send_item(ttam_pkg::ACT_LOAD, 1, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_ENERGY, 0, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_LOAD, 1, 0, 16'sd1, 16'sd0);
    send_item(ttam_pkg::ACT_LOAD, 2, 0, 16'sd2, 16'sd0);
    send_item(ttam_pkg::ACT_LOAD, 3, 0, 16'sd3, 16'sd0);
    send_item(ttam_pkg::ACT_ENERGY, 0, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_APPLY, 1, 3, 16'sd0, 16'sd0);
    // Coordinate extremes.
    send_item(ttam_pkg::ACT_LOAD, 2, 0, -16'sd32768, 16'sd32767);
    send_item(ttam_pkg::ACT_LOAD, 3, 0, 16'sd32767, -16'sd32768);
    send_item(ttam_pkg::ACT_LOAD, 255, 255, -16'sd1, -16'sd1);
    send_item(ttam_pkg::ACT_EVAL, 2, 0, 16'sd0, 16'sd0);
    send_item(ttam_pkg::ACT_ENERGY, 0, 0, 16'sd0, 16'sd0);

    for (int p = 0; p < 18; p++) begin
      quiet = (p == 3);
      run_phase(counts[p], (counts[p] > 64) ? 15 : 18, p % 4);
    end
    quiet = 1'b0;

    drain_results();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ttam_pkg.sv
hw/rtl/ttam_angle.sv
hw/rtl/ttam_dp.sv
hw/rtl/ttam_ctrl.sv
hw/rtl/tour_turn_angle_move_evaluator_core.sv
bench/tb_tour_turn_angle_move_evaluator_core.sv
